[hdl/tlmf_pkg.sv]
// Shared constants, types and helpers of the two-layer mean MLP forward unit.
`default_nettype none

package tlmf_pkg;

    // Network size limits
    localparam int MAX_INPUTS  = 16;
    localparam int MAX_HIDDEN  = 16;
    localparam int MAX_OUTPUTS = 8;

    localparam int W1_DEPTH = MAX_INPUTS * MAX_HIDDEN;
    localparam int W2_DEPTH = MAX_HIDDEN * MAX_OUTPUTS;
    localparam int W1_AW    = $clog2(W1_DEPTH);
    localparam int W2_AW    = $clog2(W2_DEPTH);
    localparam int IN_IW    = $clog2(MAX_INPUTS);
    localparam int HID_IW   = $clog2(MAX_HIDDEN);

    // Word field widths
    localparam int FUNC_W = 2;
    localparam int SLOT_W = 8;
    localparam int VAL_W  = 16;
    localparam int FRAC_W = 12;
    localparam int NODE_W = 3;

    // Count register widths
    localparam int ICNT_W = 5;
    localparam int HCNT_W = 5;
    localparam int OCNT_W = 4;
    localparam int CNT_W  = 5;

    // Exact sum of products and its Q4.12 magnitude
    localparam int MAX_SUM = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
    localparam int ACC_W   = 2 * VAL_W + $clog2(MAX_SUM) + 1;
    localparam int MAG_W   = ACC_W - FRAC_W;
    localparam int STEP_W  = $clog2(MAG_W + 1);

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_W1      = 2'd0,
        FN_W2      = 2'd1,
        FN_INPUT   = 2'd2,
        FN_COMPUTE = 2'd3
    } func_t;

    typedef struct packed {
        logic [ICNT_W-1:0] input_count;
        logic [HCNT_W-1:0] hidden_count;
        logic [OCNT_W-1:0] output_count;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             acc_clear;
        logic             rd_en;
        logic             layer;
        logic [W1_AW-1:0] addr;
        logic [CNT_W-1:0] j;
        logic             div_start;
        logic [CNT_W-1:0] div_count;
        logic             hid_we;
        logic [CNT_W-1:0] row;
        logic             out_load;
        logic             out_last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

    // Zero counts as one, anything above the limit as the limit
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                     input int maxc);
        logic [CNT_W-1:0] r;
        if (c == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(c) > maxc)
        begin
            r = CNT_W'(maxc);
        end
        else
        begin
            r = c;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/tlmf_intf.sv]
// Valid/ready channel interfaces for input words and result words.
`default_nettype none

interface tlmf_in_if
    import tlmf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output func, output slot, output value, input ready);
    modport sink   (input valid, input func, input slot, input value, output ready);
endinterface

interface tlmf_out_if
    import tlmf_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [NODE_W-1:0]       out_node;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;

    modport source (output valid, output out_node, output out_value, output last,
                    input ready);
    modport sink   (input valid, input out_node, input out_value, input last,
                    output ready);
endinterface

`default_nettype wire

[hdl/two_layer_mean_mlp_forward_unit.sv]
// Top level of the two-layer mean MLP forward unit: config registers and wiring.
//
//  channel   dir  handshake        payload
//  -------   ---  ---------------  ------------------------------------------
//  items     in   valid / ready    func[1:0], slot[7:0], value[15:0] (Q4.12)
//  results   out  valid / ready    out_node[2:0], out_value[15:0], last
//  apb       in   psel / penable   paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  A load word (weight or input node) is taken whenever idle; load words can
//  stream back to back. A compute word holds ready low while the network runs:
//  one multiply-accumulate per weight from a weight RAM read, then a 25-step
//  serial divide per node.
//  Reset (rst_n low, asynchronous) clears counts to 1 and all node values.
//  A stalled result word holds in the output register; the next word waits.
`default_nettype none

module two_layer_mean_mlp_forward_unit
    import tlmf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    tlmf_in_if.sink                items,
    tlmf_out_if.source             results,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready
);

    cfg_t  cfg_reg, cfg_next;
    cmd_t  cmd;
    stat_t stat;
    logic  cfg_we;
    logic  in_ready;

    // Write on the access phase; pready never stalls
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_INPUT_COUNT:  cfg_next.input_count  = pwdata[ICNT_W-1:0];
                REG_HIDDEN_COUNT: cfg_next.hidden_count = pwdata[HCNT_W-1:0];
                REG_OUTPUT_COUNT: cfg_next.output_count = pwdata[OCNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_count  <= ICNT_W'(1);
            cfg_reg.hidden_count <= HCNT_W'(1);
            cfg_reg.output_count <= OCNT_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the raw register values
    always_comb
    begin
        unique case (paddr[3:2])
            REG_INPUT_COUNT:  prdata = APB_DW'(cfg_reg.input_count);
            REG_HIDDEN_COUNT: prdata = APB_DW'(cfg_reg.hidden_count);
            REG_OUTPUT_COUNT: prdata = APB_DW'(cfg_reg.output_count);
            default:          prdata = '0;
        endcase
    end

    tlmf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (items.valid),
        .in_compute (func_t'(items.func) == FN_COMPUTE),
        .in_ready   (in_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    assign items.ready = in_ready;

    tlmf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_func  (items.func),
        .in_slot  (items.slot),
        .in_value (items.value),
        .out_ch   (results)
    );

endmodule

`default_nettype wire

[hdl/tlmf_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tlmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/tlmf_div.sv]
// Serial divider: exact sum over count*4096, truncated toward zero, saturated.
`default_nettype none

module tlmf_div
    import tlmf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [ACC_W-1:0] acc,
    input  wire logic [CNT_W-1:0]        count,
    output      logic                    done,
    output      logic signed [VAL_W-1:0] result
);

    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [ACC_W-1:0]  abs_acc;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    // Trunc of acc/4096 is the sign times the shifted magnitude
    assign abs_acc = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign trial   = {rem_reg, quo_reg[MAG_W-1]};
    assign diff    = trial - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = abs_acc[ACC_W-1:FRAC_W];
            rem_next  = '0;
            step_next = STEP_W'(MAG_W);
        end
        else if (step_reg != '0)
        begin
            if (!diff[CNT_W])
            begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= count;
            neg_reg <= acc[ACC_W-1];
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > MAG_W'(32768))
            begin
                result = 16'sh8000;
            end
            else
            begin
                result = VAL_W'(-quo_reg);
            end
        end
        else
        begin
            if (quo_reg > MAG_W'(32767))
            begin
                result = 16'sh7FFF;
            end
            else
            begin
                result = VAL_W'(quo_reg);
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

[hdl/tlmf_ctrl.sv]
// Controller: sequences loads, row walks, divides and result emission.
`default_nettype none

module tlmf_ctrl
    import tlmf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    input  wire logic  in_compute,
    output      logic  in_ready,
    input  wire stat_t stat,
    output      cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ROW    = 8'b0000_0010,
        ST_MAC    = 8'b0000_0100,
        ST_DRAIN1 = 8'b0000_1000,
        ST_DRAIN2 = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_WAITD  = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } ctrl_state_t;

    ctrl_state_t      state_reg, state_next;
    logic             layer_reg, layer_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [W1_AW-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] ni, nh, no, cnt_cur;
    logic             row_last;

    assign ni = clamp_count(CNT_W'(cfg.input_count), MAX_INPUTS);
    assign nh = clamp_count(CNT_W'(cfg.hidden_count), MAX_HIDDEN);
    assign no = clamp_count(CNT_W'(cfg.output_count), MAX_OUTPUTS);

    assign cnt_cur  = layer_reg ? nh : ni;
    assign row_last = layer_reg ? (row_reg == no - CNT_W'(1)) : (row_reg == nh - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        addr_next  = addr_reg;
        in_ready   = 1'b0;

        cmd           = '0;
        cmd.layer     = layer_reg;
        cmd.addr      = addr_reg;
        cmd.j         = j_reg;
        cmd.div_count = cnt_cur;
        cmd.row       = row_reg;
        cmd.out_last  = row_last;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_compute)
                begin
                    layer_next = 1'b0;
                    row_next   = '0;
                    addr_next  = '0;
                    state_next = ST_ROW;
                end
                else if (in_valid)
                begin
                    cmd.load = 1'b1;
                end
            end
            ST_ROW:
            begin
                cmd.acc_clear = 1'b1;
                j_next        = '0;
                state_next    = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.rd_en = 1'b1;
                addr_next = addr_reg + W1_AW'(1);
                j_next    = j_reg + CNT_W'(1);
                if (j_reg == cnt_cur - CNT_W'(1))
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1:
            begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAITD;
            end
            ST_WAITD:
            begin
                if (stat.div_done)
                begin
                    if (layer_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.hid_we = 1'b1;
                        state_next = ST_ROW;
                        if (row_last)
                        begin
                            layer_next = 1'b1;
                            row_next   = '0;
                            addr_next  = '0;
                        end
                        else
                        begin
                            row_next = row_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + CNT_W'(1);
                        state_next = ST_ROW;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            layer_reg <= 1'b0;
            row_reg   <= '0;
            j_reg     <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            row_reg   <= row_next;
            j_reg     <= j_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tlmf_dp.sv]
// Datapath: node stores, weight RAMs, MAC pipeline, divider and result register.
`default_nettype none

module tlmf_dp
    import tlmf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    output      stat_t                   stat,
    input  wire logic [FUNC_W-1:0]       in_func,
    input  wire logic [SLOT_W-1:0]       in_slot,
    input  wire logic signed [VAL_W-1:0] in_value,
    tlmf_out_if.source                   out_ch
);

    logic signed [VAL_W-1:0] input_reg  [MAX_INPUTS];
    logic signed [VAL_W-1:0] hidden_reg [MAX_HIDDEN];

    logic                      w1_we, w2_we, in_we;
    logic [VAL_W-1:0]          w1_rdata, w2_rdata;
    logic                      v1_reg, layer1_reg, v2_reg;
    logic [CNT_W-1:0]          j1_reg;
    logic signed [VAL_W-1:0]   oper_a, oper_b;
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      div_done;
    logic signed [VAL_W-1:0]   div_result;

    logic                    out_valid_reg;
    logic [NODE_W-1:0]       out_node_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_last_reg;

    // Drop writes whose slot lies beyond the store
    assign w1_we = cmd.load && (func_t'(in_func) == FN_W1) && (int'(in_slot) < W1_DEPTH);
    assign w2_we = cmd.load && (func_t'(in_func) == FN_W2) && (int'(in_slot) < W2_DEPTH);
    assign in_we = cmd.load && (func_t'(in_func) == FN_INPUT) &&
                   (int'(in_slot) < MAX_INPUTS);

    tlmf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (W1_DEPTH)
    ) u_w1_ram (
        .clk   (clk),
        .we    (w1_we),
        .waddr (W1_AW'(in_slot)),
        .wdata (in_value),
        .re    (cmd.rd_en && !cmd.layer),
        .raddr (cmd.addr),
        .rdata (w1_rdata)
    );

    tlmf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (W2_DEPTH)
    ) u_w2_ram (
        .clk   (clk),
        .we    (w2_we),
        .waddr (W2_AW'(in_slot)),
        .wdata (in_value),
        .re    (cmd.rd_en && cmd.layer),
        .raddr (W2_AW'(cmd.addr)),
        .rdata (w2_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_INPUTS; i++)
            begin
                input_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_HIDDEN; i++)
            begin
                hidden_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_we)
            begin
                input_reg[IN_IW'(in_slot)] <= in_value;
            end
            if (cmd.hid_we)
            begin
                hidden_reg[HID_IW'(cmd.row)] <= div_result;
            end
        end
    end

    // MAC pipeline: RAM read, multiply, accumulate
    assign oper_a = layer1_reg ? signed'(w2_rdata) : signed'(w1_rdata);
    assign oper_b = layer1_reg ? hidden_reg[HID_IW'(j1_reg)] : input_reg[IN_IW'(j1_reg)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        layer1_reg <= cmd.layer;
        j1_reg     <= cmd.j;
        prod_reg   <= oper_a * oper_b;
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    tlmf_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .acc    (acc_reg),
        .count  (cmd.div_count),
        .done   (div_done),
        .result (div_result)
    );

    // Result register, freed when the sink takes the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_node_reg  <= NODE_W'(cmd.row);
            out_value_reg <= div_result;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_node  = out_node_reg;
    assign out_ch.out_value = out_value_reg;
    assign out_ch.last      = out_last_reg;

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ch.ready;

endmodule

`default_nettype wire

[hdl/tlmf_checker.sv]
// Port-level checker for the forward unit and its bind to the top level.
`default_nettype none

module tlmf_checker
    import tlmf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [FUNC_W-1:0] in_func,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [NODE_W-1:0] out_node,
    input wire logic [VAL_W-1:0]  out_value,
    input wire logic              out_last
);

    logic [NODE_W-1:0] exp_node_reg;

    // Track the node number the next result word must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_node_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_node_reg <= out_last ? '0 : out_node + NODE_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_node) &&
                                    $stable(out_value) && $stable(out_last))
        else $error("result word changed while stalled");

    a_node_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_node == exp_node_reg)
        else $error("result nodes out of order");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func_t'(in_func) == FN_COMPUTE) |=> !in_ready)
        else $error("input taken right after a compute word");

endmodule

bind two_layer_mean_mlp_forward_unit tlmf_checker u_tlmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_func   (items.func),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_node  (results.out_node),
    .out_value (results.out_value),
    .out_last  (results.last)
);

`default_nettype wire
